// File: rtl/core/edp_pkg.sv
// ----------------------------------------------------------------------------
// edp_pkg: shared types and constants for the edit distance engine
// Holds the control word that travels along the cell chain and the fixed
// field widths of the request and response words.
// ----------------------------------------------------------------------------
package edp_pkg;

   localparam int SYM_W  = 8;
   localparam int DIST_W = 9;

   // largest distance the response word can carry
   localparam logic [DIST_W-1:0] DIST_MAX = 9'd511;

   // control word handed from cell to cell with each table row
   typedef struct packed {
      logic valid;   // a row is present on this link
      logic last;    // this is the final row of the pair
   } edp_ctl_type;

endpackage

// File: rtl/core/edp_req_if.sv
// ----------------------------------------------------------------------------
// edp_req_if: request channel
// One word per string symbol, with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface edp_req_if;

   logic                     valid;
   logic                     ready;
   logic                     which_string;
   logic                     has_symbol;
   logic [edp_pkg::SYM_W-1:0] symbol;
   logic                     end_of_pair;

   modport source (output valid, which_string, has_symbol, symbol, end_of_pair,
                   input ready);
   modport sink   (input valid, which_string, has_symbol, symbol, end_of_pair,
                   output ready);

endinterface

// File: rtl/core/edp_rsp_if.sv
// ----------------------------------------------------------------------------
// edp_rsp_if: response channel
// One word per closed string pair, with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface edp_rsp_if;

   logic                      valid;
   logic                      ready;
   logic [edp_pkg::DIST_W-1:0] distance;
   logic                      too_long;

   modport source (output valid, distance, too_long, input ready);
   modport sink   (input valid, distance, too_long, output ready);

endinterface

// File: rtl/core/edit_distance_dp_core.sv
// ----------------------------------------------------------------------------
// edit_distance_dp_core: Levenshtein edit distance engine
// The closing word starts INIT, then FEED and DRAIN; WAIT_OUT then loads
//   the response word. INIT goes straight to WAIT_OUT when the first
//   string is empty. Throughput: one symbol word per cycle while loading;
//   one pair at a time, set by the row sweep through the MAX_LEN-cell chain.
// Reset: synchronous, clears counts, flags, FSM and chain control; the
//   symbol stores hold whatever they had until written.
// ----------------------------------------------------------------------------
module edit_distance_dp_core #(
   parameter int MAX_LEN = 256
) (
   input  logic       clock,
   input  logic       reset,
   edp_req_if.sink    req_ch,
   edp_rsp_if.source  rsp_ch
);

   localparam int VW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam logic [VW-1:0] LEN_LIMIT = VW'(MAX_LEN);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_INIT,
      ST_FEED,
      ST_DRAIN,
      ST_WAIT_OUT
   } state_type;

   state_type state_ff;

   logic [VW-1:0]                 first_count_ff;
   logic [VW-1:0]                 second_count_ff;
   logic                          overflow_ff;
   logic [AW-1:0]                 feed_idx_ff;

   // row issue stage feeding the head of the chain
   edp_pkg::edp_ctl_type          issue_ctl_ff;
   logic [edp_pkg::SYM_W-1:0]     rd_sym_ff;
   logic [VW-1:0]                 issue_row_ff;

   // response register
   logic                          rsp_valid_ff;
   logic [edp_pkg::DIST_W-1:0]    distance_ff;
   logic                          too_long_ff;

   logic [edp_pkg::SYM_W-1:0]     first_mem [MAX_LEN];

   logic                          req_fire;
   logic                          first_wr;
   logic                          second_wr;
   logic                          first_full;
   logic                          second_full;
   logic                          feed_last;
   logic                          out_free;
   logic                          rsp_load;
   logic [VW+edp_pkg::DIST_W-1:0] tail_ext;
   logic [edp_pkg::DIST_W-1:0]    tail_dist;

   edp_pkg::edp_ctl_type          ctl_link  [MAX_LEN+1];
   logic [edp_pkg::SYM_W-1:0]     sym_link  [MAX_LEN+1];
   logic [VW-1:0]                 val_link  [MAX_LEN+1];
   logic [VW-1:0]                 diag_link [MAX_LEN+1];

   // handshake and store decode
   always_comb begin
      req_fire    = req_ch.valid && (state_ff == ST_LOAD);
      first_full  = (first_count_ff  >= LEN_LIMIT);
      second_full = (second_count_ff >= LEN_LIMIT);
      first_wr    = req_fire && req_ch.has_symbol && !req_ch.which_string && !first_full;
      second_wr   = req_fire && req_ch.has_symbol &&  req_ch.which_string && !second_full;
      feed_last   = (VW'(feed_idx_ff) == (first_count_ff - VW'(1)));
      out_free    = !rsp_valid_ff || rsp_ch.ready;
      rsp_load    = (state_ff == ST_WAIT_OUT) && out_free;
   end

   // saturate the tail score into the response width
   always_comb begin
      tail_ext  = {{edp_pkg::DIST_W{1'b0}}, val_link[MAX_LEN]};
      tail_dist = (tail_ext > (VW+edp_pkg::DIST_W)'(edp_pkg::DIST_MAX)) ?
                  edp_pkg::DIST_MAX : tail_ext[edp_pkg::DIST_W-1:0];
   end

   // first string store: written while loading, read once per row
   always_ff @(posedge clock) begin
      if (first_wr) begin
         first_mem[first_count_ff[AW-1:0]] <= req_ch.symbol;
      end
      if (state_ff == ST_FEED) begin
         rd_sym_ff <= first_mem[feed_idx_ff];
      end
   end

   // sequencer, counts and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         overflow_ff     <= 1'b0;
         feed_idx_ff     <= '0;
         issue_ctl_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         // response valid: set on a new word, cleared once taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // one row of the first string per cycle while feeding
         issue_ctl_ff.valid <= (state_ff == ST_FEED);
         issue_ctl_ff.last  <= (state_ff == ST_FEED) && feed_last;
         unique case (state_ff)
            ST_LOAD: begin
               if (first_wr) begin
                  first_count_ff <= first_count_ff + VW'(1);
               end
               if (second_wr) begin
                  second_count_ff <= second_count_ff + VW'(1);
               end
               if (req_fire && req_ch.has_symbol &&
                   (req_ch.which_string ? second_full : first_full)) begin
                  overflow_ff <= 1'b1;
               end
               if (req_fire && req_ch.end_of_pair) begin
                  state_ff <= ST_INIT;
               end
            end
            ST_INIT: begin
               feed_idx_ff <= '0;
               state_ff    <= (first_count_ff == '0) ? ST_WAIT_OUT : ST_FEED;
            end
            ST_FEED: begin
               issue_row_ff       <= VW'(feed_idx_ff) + VW'(1);
               feed_idx_ff        <= feed_idx_ff + AW'(1);
               if (feed_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (ctl_link[MAX_LEN].valid && ctl_link[MAX_LEN].last) begin
                  state_ff <= ST_WAIT_OUT;
               end
            end
            ST_WAIT_OUT: begin
               if (out_free) begin
                  distance_ff     <= tail_dist;
                  too_long_ff     <= overflow_ff;
                  first_count_ff  <= '0;
                  second_count_ff <= '0;
                  overflow_ff     <= 1'b0;
                  state_ff        <= ST_LOAD;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   // chain head: left border score i and diagonal i-1
   assign ctl_link[0]  = issue_ctl_ff;
   assign sym_link[0]  = rd_sym_ff;
   assign val_link[0]  = issue_row_ff;
   assign diag_link[0] = issue_row_ff - VW'(1);

   // one cell per column of the second string
   for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
      edp_cell #(
         .VW    (VW),
         .AW    (AW),
         .INDEX (j)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .init     (state_ff == ST_INIT),
         .m_len    (second_count_ff),
         .load_en  (second_wr),
         .load_idx (second_count_ff[AW-1:0]),
         .load_sym (req_ch.symbol),
         .in_ctl   (ctl_link[j-1]),
         .in_sym   (sym_link[j-1]),
         .in_val   (val_link[j-1]),
         .in_diag  (diag_link[j-1]),
         .out_ctl  (ctl_link[j]),
         .out_sym  (sym_link[j]),
         .out_val  (val_link[j]),
         .out_diag (diag_link[j])
      );
   end

   assign req_ch.ready    = (state_ff == ST_LOAD);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.distance = distance_ff;
   assign rsp_ch.too_long = too_long_ff;

endmodule

// File: rtl/core/edp_cell.sv
// ----------------------------------------------------------------------------
// edp_cell: one column of the edit distance table
// Holds one symbol of the second string and the column's current score.
// Each row of the first string arrives from the left neighbor in the cycle
// after that neighbor has scored it, and is passed on to the right.
// Columns past the end of the second string copy the left score through,
// so the last cell of the chain always ends up with the bottom-right cell.
// ----------------------------------------------------------------------------
module edp_cell #(
   parameter int VW    = 9,    // score width
   parameter int AW    = 8,    // symbol index width
   parameter int INDEX = 1     // column number, 1-based
) (
   input  logic                       clock,
   input  logic                       reset,
   // pair setup
   input  logic                       init,
   input  logic [VW-1:0]              m_len,
   input  logic                       load_en,
   input  logic [AW-1:0]              load_idx,
   input  logic [edp_pkg::SYM_W-1:0]  load_sym,
   // from left neighbor
   input  edp_pkg::edp_ctl_type       in_ctl,
   input  logic [edp_pkg::SYM_W-1:0]  in_sym,
   input  logic [VW-1:0]              in_val,
   input  logic [VW-1:0]              in_diag,
   // to right neighbor
   output edp_pkg::edp_ctl_type       out_ctl,
   output logic [edp_pkg::SYM_W-1:0]  out_sym,
   output logic [VW-1:0]              out_val,
   output logic [VW-1:0]              out_diag
);

   localparam logic [VW-1:0] COL = VW'(INDEX);

   logic [edp_pkg::SYM_W-1:0] col_sym_ff;
   logic [edp_pkg::SYM_W-1:0] row_sym_ff;
   logic [VW-1:0]             val_ff;
   logic [VW-1:0]             old_ff;
   logic                      thru_ff;
   edp_pkg::edp_ctl_type      ctl_ff;

   logic                      cost;
   logic [VW:0]               diag_sum;
   logic [VW:0]               up_sum;
   logic [VW:0]               left_sum;
   logic [VW:0]               best_a;
   logic [VW:0]               best_in;

   // unit-cost recurrence: min of diagonal, up and left
   always_comb begin
      cost     = (in_sym != col_sym_ff);
      diag_sum = {1'b0, in_diag} + {{VW{1'b0}}, cost};
      up_sum   = {1'b0, val_ff}  + (VW+1)'(1);
      left_sum = {1'b0, in_val}  + (VW+1)'(1);
      best_a   = (diag_sum < up_sum) ? diag_sum : up_sum;
      best_in  = (best_a < left_sum) ? best_a : left_sum;
   end

   // column symbol, captured while the second string loads
   always_ff @(posedge clock) begin
      if (load_en && (load_idx == AW'(INDEX - 1))) begin
         col_sym_ff <= load_sym;
      end
   end

   // score and row pass-through
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff  <= '0;
         thru_ff <= 1'b0;
      end else if (init) begin
         // top border: column score is its index, clamped past the string end
         ctl_ff  <= '0;
         thru_ff <= (m_len < COL);
         val_ff  <= (m_len < COL) ? m_len : COL;
      end else if (in_ctl.valid) begin
         ctl_ff     <= in_ctl;
         row_sym_ff <= in_sym;
         old_ff     <= val_ff;
         val_ff     <= thru_ff ? in_val : best_in[VW-1:0];
      end else begin
         ctl_ff <= '0;
      end
   end

   assign out_ctl  = ctl_ff;
   assign out_sym  = row_sym_ff;
   assign out_val  = val_ff;
   assign out_diag = old_ff;

endmodule

// File: rtl/core/edp_checker.sv
// ----------------------------------------------------------------------------
// edp_checker: port-level checks for the edit distance engine
// Tracks closed pairs against response words and watches the response word.
// ----------------------------------------------------------------------------
module edp_checker #(
   parameter int MAX_LEN = 256
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_end_of_pair,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [edp_pkg::DIST_W-1:0] rsp_distance
);

   logic [1:0] pending_ff;
   logic       close_fire;
   logic       rsp_fire;

   assign close_fire = req_valid && req_ready && req_end_of_pair;
   assign rsp_fire   = rsp_valid && rsp_ready;

   // closed pairs whose response word is not yet taken
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (close_fire && !rsp_fire) begin
         pending_ff <= pending_ff + 2'd1;
      end else if (!close_fire && rsp_fire) begin
         pending_ff <= pending_ff - 2'd1;
      end
   end

   // a stalled response word stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // a response word only follows a closed pair
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (pending_ff != 2'd0))
      else $error("response word without a closed pair");

   // at most one pair computing behind one waiting response word
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many pairs in flight");

   // distance never exceeds the longest string the block can hold
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_distance) <= 32'(MAX_LEN)))
      else $error("distance out of range");

endmodule

bind edit_distance_dp_core edp_checker #(.MAX_LEN(MAX_LEN)) u_edp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_end_of_pair (req_ch.end_of_pair),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_distance    (rsp_ch.distance)
);
